### src/mbdl_pkg.sv
// ----------------------------------------------------------------------------
// mbdl_pkg
// shared constants, types and helpers of the multi-button debounce latch
// ----------------------------------------------------------------------------
package mbdl_pkg;

    // number of button channels, 1 to 16
    localparam int NUM_CHANNELS = 2;

    localparam int PIN_W   = 16;
    localparam int TIME_W  = 32;
    localparam int LIMIT_W = 16;
    localparam int CH_W    = 4;
    localparam int CH_CNT_W = 5;   // holds NUM_CHANNELS itself
    localparam int COUNT_W = 5;
    localparam int CFG_IDX_W = 2;

    // item opcodes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_READ = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_ENABLE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_MS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LOW_MASK = 2'd2;

    // configuration reset values
    localparam logic               RST_BLOCK_ENABLE    = 1'b1;
    localparam logic [LIMIT_W-1:0] RST_DEBOUNCE_MS     = 16'd50;
    localparam logic [PIN_W-1:0]   RST_ACTIVE_LOW_MASK = 16'd3;

    // broadcast to every lane for one tick beat
    typedef struct packed {
        logic               tick;
        logic [TIME_W-1:0]  now_ms;
        logic [LIMIT_W-1:0] debounce_ms;
    } t_tick_cmd;

    // one result beat
    typedef struct packed {
        logic               clicked;
        logic [PIN_W-1:0]   bitmap;
        logic [COUNT_W-1:0] count;
    } t_result;

    // population count as four nibble counts and a final add
    function automatic logic [COUNT_W-1:0] popcount16(input logic [PIN_W-1:0] v);
        logic [2:0] nib [4];
        logic [COUNT_W-1:0] sum;
        sum = '0;
        for (int n = 0; n < 4; n++) begin
            nib[n] = 3'(v[4*n]) + 3'(v[4*n+1]) + 3'(v[4*n+2]) + 3'(v[4*n+3]);
        end
        for (int n = 0; n < 4; n++) begin
            sum = sum + COUNT_W'(nib[n]);
        end
        return sum;
    endfunction

endpackage

### src/mbdl_lane.sv
// ----------------------------------------------------------------------------
// mbdl_lane
// one channel: idle / debouncing / pressed state machine and sticky latch
// ----------------------------------------------------------------------------
module mbdl_lane
    import mbdl_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_tick_cmd i_cmd,
    input  logic      i_active,
    input  logic      i_clear,
    output logic      o_latch,
    output logic      o_latch_next
);

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_DEB     = 2'd1;
    localparam logic [1:0] PH_PRESSED = 2'd2;

    logic [1:0]        r_phase, n_phase;
    logic [TIME_W-1:0] r_start, n_start;
    logic              r_latch, n_latch;
    logic [TIME_W-1:0] elapsed;
    logic              limit_hit;

    // elapsed time wraps modulo 2^32
    assign elapsed   = i_cmd.now_ms - r_start;
    assign limit_hit = elapsed >= {{(TIME_W-LIMIT_W){1'b0}}, i_cmd.debounce_ms};

    always_comb begin
        n_phase = r_phase;
        n_start = r_start;
        n_latch = r_latch;
        if (i_cmd.tick) begin
            case (r_phase)
                PH_DEB: begin
                    if (limit_hit) begin
                        n_latch = 1'b1;
                        n_phase = PH_PRESSED;
                    end else if (!i_active) begin
                        n_phase = PH_IDLE;
                    end
                end
                PH_PRESSED: begin
                    if (!i_active) begin
                        n_phase = PH_IDLE;
                    end
                end
                default: begin
                    if (i_active) begin
                        n_start = i_cmd.now_ms;
                        n_phase = PH_DEB;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
            endcase
        end
        if (i_clear) begin
            n_latch = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_latch <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_latch <= n_latch;
        end
    end

    // start time needs no reset, only read after debouncing wrote it
    always_ff @(posedge i_clk) begin
        r_start <= n_start;
    end

    assign o_latch      = r_latch;
    assign o_latch_next = r_latch | ((r_phase == PH_DEB) & limit_hit);

endmodule

### src/mbdl_merge.sv
// ----------------------------------------------------------------------------
// mbdl_merge
// combines lane latches into the result beat, with output register and skid
// ----------------------------------------------------------------------------
module mbdl_merge
    import mbdl_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  logic             i_op,
    input  logic [CH_W-1:0]  i_channel,
    input  logic             i_enable,
    input  logic [PIN_W-1:0] i_latch_cur,
    input  logic [PIN_W-1:0] i_latch_tick,
    input  logic             i_out_ready,
    output logic             o_in_ready,
    output logic             o_out_valid,
    output t_result          o_result
);

    t_result          res;
    logic [PIN_W-1:0] raw_bm;
    logic             ch_ok;

    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out, n_out;
    t_result r_skid, n_skid;
    logic    pop;

    // ticks report after their update, reads before any clear
    assign raw_bm = (i_op == OP_READ) ? i_latch_cur : i_latch_tick;
    assign ch_ok  = {1'b0, i_channel} < CH_CNT_W'(NUM_CHANNELS);

    always_comb begin
        res.bitmap  = i_enable ? raw_bm : '0;
        res.count   = popcount16(res.bitmap);
        res.clicked = (i_op == OP_READ) & i_enable & ch_ok & i_latch_cur[i_channel];
    end

    assign pop = r_out_valid & i_out_ready;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (pop) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end else if (i_load) begin
                n_out = res;
            end else begin
                n_out_valid = 1'b0;
            end
        end else if (i_load) begin
            if (!r_out_valid) begin
                n_out       = res;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = res;
                n_skid_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_in_ready  = ~r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

endmodule

### src/multi_button_debounce_latch.sv
// ----------------------------------------------------------------------------
// multi_button_debounce_latch
// debouncer for several buttons with sticky click latches
// ----------------------------------------------------------------------------
// Each channel runs its own idle / debouncing / pressed state machine in a
// lane of its own; all lanes update together on a tick beat. A tick carries a
// millisecond timestamp and the raw pin levels; a read beat returns one
// channel's click latch and may clear it. Every beat yields exactly one result
// beat with the clicked bit, the enable-gated latch bitmap and its count. The
// block takes one beat per clock cycle, back to back, while o_in_ready is high;
// each result is registered in the output register or, while that waits, in
// a skid register behind it, which keeps i_in_valid flowing, so o_in_ready
// drops only when both hold unread results. The configuration port is always
// ready; write it only while the block is idle.
// ----------------------------------------------------------------------------
module multi_button_debounce_latch
    import mbdl_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [PIN_W-1:0]     i_cfg_data,
    // input beats
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_op,
    input  logic [TIME_W-1:0]    i_now_ms,
    input  logic [PIN_W-1:0]     i_pin_levels,
    input  logic [CH_W-1:0]      i_channel,
    input  logic                 i_clear_after_read,
    // result beats
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_clicked,
    output logic [PIN_W-1:0]     o_pressed_bitmap,
    output logic [COUNT_W-1:0]   o_pressed_count
);

    // configuration registers
    logic               r_enable;
    logic [LIMIT_W-1:0] r_debounce_ms;
    logic [PIN_W-1:0]   r_active_low_mask;

    logic               in_accept;
    logic               cfg_accept;
    t_tick_cmd          tick_cmd;
    logic [PIN_W-1:0]   active;
    logic [PIN_W-1:0]   latch_cur;
    logic [PIN_W-1:0]   latch_tick;
    logic               read_clear;
    logic [CH_CNT_W-1:0] ch_ext;
    t_result            result;

    assign o_cfg_ready = 1'b1;
    assign cfg_accept  = i_cfg_valid & o_cfg_ready;
    assign in_accept   = i_in_valid & o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable          <= RST_BLOCK_ENABLE;
            r_debounce_ms     <= RST_DEBOUNCE_MS;
            r_active_low_mask <= RST_ACTIVE_LOW_MASK;
        end else if (cfg_accept) begin
            case (i_cfg_index)
                CFG_BLOCK_ENABLE:    r_enable          <= i_cfg_data[0];
                CFG_DEBOUNCE_MS:     r_debounce_ms     <= i_cfg_data;
                CFG_ACTIVE_LOW_MASK: r_active_low_mask <= i_cfg_data;
                default: begin
                    // unknown index: ignored
                end
            endcase
        end
    end

    // pin is active when its level differs from the active-low bit
    assign active = i_pin_levels ^ r_active_low_mask;

    always_comb begin
        tick_cmd.tick        = in_accept & (i_op == OP_TICK);
        tick_cmd.now_ms      = i_now_ms;
        tick_cmd.debounce_ms = r_debounce_ms;
    end

    // a read clears only an in-range channel while the block is enabled
    assign ch_ext     = {1'b0, i_channel};
    assign read_clear = in_accept & (i_op == OP_READ) & r_enable & i_clear_after_read
                      & (ch_ext < CH_CNT_W'(NUM_CHANNELS));

    genvar g;
    generate
        for (g = 0; g < NUM_CHANNELS; g++) begin : g_lane
            mbdl_lane u_lane (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_cmd        (tick_cmd),
                .i_active     (active[g]),
                .i_clear      (read_clear & (i_channel == CH_W'(g))),
                .o_latch      (latch_cur[g]),
                .o_latch_next (latch_tick[g])
            );
        end
        // channels beyond the lane count report zero
        if (NUM_CHANNELS < PIN_W) begin : g_pad
            assign latch_cur[PIN_W-1:NUM_CHANNELS]  = '0;
            assign latch_tick[PIN_W-1:NUM_CHANNELS] = '0;
        end
    endgenerate

    mbdl_merge u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (in_accept),
        .i_op         (i_op),
        .i_channel    (i_channel),
        .i_enable     (r_enable),
        .i_latch_cur  (latch_cur),
        .i_latch_tick (latch_tick),
        .i_out_ready  (i_out_ready),
        .o_in_ready   (o_in_ready),
        .o_out_valid  (o_out_valid),
        .o_result     (result)
    );

    assign o_clicked        = result.clicked;
    assign o_pressed_bitmap = result.bitmap;
    assign o_pressed_count  = result.count;

`ifndef SYNTHESIS
    // count always matches the bitmap it travels with
    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_pressed_count == COUNT_W'($countones(o_pressed_bitmap))))
        else $error("pressed count does not match bitmap");

    // no bitmap bit above the last channel
    a_bitmap_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_pressed_bitmap >> NUM_CHANNELS) == '0))
        else $error("bitmap bit set beyond channel count");

    // a clicked read is always reflected in the pre-clear bitmap
    a_clicked_in_bitmap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_clicked) |-> (o_pressed_bitmap != '0))
        else $error("clicked set with empty bitmap");

    // input stalls only while the output register holds a beat
    a_stall_needs_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with empty output register");

    // an accepted beat always leaves the output register valid next cycle
    a_accept_to_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_out_valid)
        else $error("accepted beat produced no result");
`endif

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the multi-button debounce latch
// ----------------------------------------------------------------------------
// Tick and read beats go in through the valid/ready input channel. A
// behavioral copy of the per-channel debounce state machines, the click
// latches and the register file works out the report owed for each accepted
// beat and queues it. A monitor pops one report per result beat and compares
// clicked, bitmap and count. Directed beats cover the reset state and the
// corner cases. Random rounds follow under different register settings and
// idle patterns, then a back-pressure test. A watchdog ends a run that stops
// making progress.
// ----------------------------------------------------------------------------
module tb_top
    import mbdl_pkg::*;
;

    // cycles without any handshake before the run is declared hung
    localparam int WATCHDOG_LIMIT  = 2000;
    // long receiver hold-off used to fill the block and stall its input
    localparam int HOLD_OFF_CYCLES = 200;
    // beats per random round
    localparam int ROUND_BEATS     = 82;
    // register index past the end of the register list, must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        BTN_RELEASED = 2'd0,
        BTN_SETTLING = 2'd1,
        BTN_HELD     = 2'd2
    } t_btn_phase;

    // one input beat
    typedef struct packed {
        logic               op;
        logic [TIME_W-1:0]  now_ms;
        logic [PIN_W-1:0]   pins;
        logic [CH_W-1:0]    channel;
        logic               clear;
    } t_beat;

    // dut ports
    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [PIN_W-1:0]     i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic                 i_op;
    logic [TIME_W-1:0]    i_now_ms;
    logic [PIN_W-1:0]     i_pin_levels;
    logic [CH_W-1:0]      i_channel;
    logic                 i_clear_after_read;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic                 o_clicked;
    logic [PIN_W-1:0]     o_pressed_bitmap;
    logic [COUNT_W-1:0]   o_pressed_count;

    // bench copy of the register file
    logic                 cfg_en;
    logic [LIMIT_W-1:0]   cfg_limit;
    logic [PIN_W-1:0]     cfg_mask;

    // bench copy of the channel state
    t_btn_phase              btn_phase   [NUM_CHANNELS];
    logic [TIME_W-1:0]       press_start [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] click_latch;

    // reports owed by the block, oldest first
    t_result owed_reports [$];

    int mismatches;
    int snd_idle_pct;
    int rcv_stall_pct;
    int hold_left;
    int quiet_cycles;

    multi_button_debounce_latch i_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------

    // advances the channel state by one beat and returns the report it owes
    function automatic t_result predict_report(input t_beat b);
        t_result           r;
        logic [PIN_W-1:0]  active;
        logic [TIME_W-1:0] elapsed;
        r = '0;
        if (b.op == OP_TICK) begin
            // a pin is active when its level differs from its mask bit
            active = b.pins ^ cfg_mask;
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                // modulo 2^32, so the timestamp may wrap
                elapsed = b.now_ms - press_start[c];
                case (btn_phase[c])
                    BTN_SETTLING: begin
                        // time limit wins over a released pin
                        if (elapsed >= TIME_W'(cfg_limit)) begin
                            click_latch[c] = 1'b1;
                            btn_phase[c]   = BTN_HELD;
                        end else if (!active[c]) begin
                            btn_phase[c] = BTN_RELEASED;
                        end
                    end
                    BTN_HELD: begin
                        if (!active[c]) begin
                            btn_phase[c] = BTN_RELEASED;
                        end
                    end
                    default: begin
                        if (active[c]) begin
                            press_start[c] = b.now_ms;
                            btn_phase[c]   = BTN_SETTLING;
                        end else begin
                            btn_phase[c] = BTN_RELEASED;
                        end
                    end
                endcase
            end
        end
        // bitmap follows a tick's update but precedes a read's clear
        if (cfg_en) begin
            r.bitmap[NUM_CHANNELS-1:0] = click_latch;
        end
        for (int k = 0; k < PIN_W; k++) begin
            r.count = r.count + COUNT_W'(r.bitmap[k]);
        end
        // reads of a missing channel or of a disabled block give zero
        if (b.op == OP_READ && b.channel < NUM_CHANNELS && cfg_en) begin
            r.clicked = click_latch[b.channel];
            if (b.clear) begin
                click_latch[b.channel] = 1'b0;
            end
        end
        return r;
    endfunction

    // tick beat; channel and clear are don't-cares and get random values
    function automatic t_beat tick_beat(input logic [TIME_W-1:0] now,
                                        input logic [PIN_W-1:0]  pins);
        t_beat b;
        b         = '0;
        b.op      = OP_TICK;
        b.now_ms  = now;
        b.pins    = pins;
        b.channel = CH_W'($urandom());
        b.clear   = 1'($urandom());
        return b;
    endfunction

    // read beat; timestamp and pins are don't-cares and get random values
    function automatic t_beat read_beat(input logic [CH_W-1:0] ch, input logic clear);
        t_beat b;
        b         = '0;
        b.op      = OP_READ;
        b.now_ms  = $urandom();
        b.pins    = PIN_W'($urandom());
        b.channel = ch;
        b.clear   = clear;
        return b;
    endfunction

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------

    // offers one beat, holds it until accepted, then queues its report
    task automatic send_beat(input t_beat b);
        if ($urandom_range(99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid         <= 1'b1;
        i_op               <= b.op;
        i_now_ms           <= b.now_ms;
        i_pin_levels       <= b.pins;
        i_channel          <= b.channel;
        i_clear_after_read <= b.clear;
        do @(posedge i_clk); while (!o_in_ready);
        owed_reports.push_back(predict_report(b));
    endtask

    // stops offering beats until every owed report has come back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (owed_reports.size() != 0) @(posedge i_clk);
    endtask

    // writes all three registers back to back, optionally a dead index too
    task automatic write_cfg(input logic en, input logic [LIMIT_W-1:0] limit,
                             input logic [PIN_W-1:0] mask, input bit poke_unused);
        logic [CFG_IDX_W-1:0] idx  [4];
        logic [PIN_W-1:0]     data [4];
        int                   beats;
        // upper bits of the enable write are junk that must be dropped
        idx[0]  = CFG_BLOCK_ENABLE;
        data[0] = {15'($urandom()), en};
        idx[1]  = CFG_DEBOUNCE_MS;
        data[1] = limit;
        idx[2]  = CFG_ACTIVE_LOW_MASK;
        data[2] = mask;
        idx[3]  = CFG_UNUSED;
        data[3] = PIN_W'($urandom());
        beats   = poke_unused ? 4 : 3;
        wait_drained();
        @(posedge i_clk);
        for (int k = 0; k < beats; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= data[k];
            do @(posedge i_clk); while (!o_cfg_ready);
            case (idx[k])
                CFG_BLOCK_ENABLE:    cfg_en    = data[k][0];
                CFG_DEBOUNCE_MS:     cfg_limit = data[k];
                CFG_ACTIVE_LOW_MASK: cfg_mask  = data[k];
                default: ;
            endcase
        end
        i_cfg_valid <= 1'b0;
    endtask

    // result side: random stalls, or a long hold-off when one is requested
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------

    always @(posedge i_clk) begin : check_reports
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (owed_reports.size() == 0) begin
                $display("%0t: unexpected result beat: clicked %0b bitmap %h count %0d",
                         $time, o_clicked, o_pressed_bitmap, o_pressed_count);
                mismatches++;
            end else begin
                want = owed_reports.pop_front();
                if (o_clicked !== want.clicked) begin
                    $display("%0t: clicked expected %0b actual %0b",
                             $time, want.clicked, o_clicked);
                    mismatches++;
                end
                if (o_pressed_bitmap !== want.bitmap) begin
                    $display("%0t: pressed_bitmap expected %h actual %h",
                             $time, want.bitmap, o_pressed_bitmap);
                    mismatches++;
                end
                if (o_pressed_count !== want.count) begin
                    $display("%0t: pressed_count expected %0d actual %0d",
                             $time, want.count, o_pressed_count);
                    mismatches++;
                end
            end
        end
    end

    // any handshake on any channel counts as progress
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // reset registers: enable on, 50 ms limit, both channels active low
    task automatic test_reset_values();
        send_beat(read_beat(CH_W'(0), 1'b0));
        send_beat(tick_beat(32'd0, 16'hFFFC));     // both pins low: settling
        send_beat(tick_beat(32'd49, 16'hFFFC));    // one short of the limit
        send_beat(tick_beat(32'd50, 16'h0002));    // ch1 released, limit still wins
        send_beat(read_beat(CH_W'(0), 1'b0));
        send_beat(read_beat(CH_W'(0), 1'b1));      // read then clear
        send_beat(read_beat(CH_W'(0), 1'b0));      // cleared
        send_beat(read_beat(CH_W'(15), 1'b1));     // highest channel code
        send_beat(tick_beat(32'd60, 16'h0003));    // both released: held to idle
    endtask

    task automatic test_special_cases();
        // zero limit, active-high pins, plus a write to a dead index
        write_cfg(1'b1, 16'd0, 16'h0000, 1'b1);
        send_beat(tick_beat(32'd100, 16'h0001));
        send_beat(tick_beat(32'd100, 16'h0000));   // latches on the next tick
        send_beat(read_beat(CH_W'(0), 1'b1));
        // elapsed time across the timestamp wrap
        write_cfg(1'b1, 16'd20, 16'h0000, 1'b0);
        send_beat(tick_beat(32'hFFFF_FFF0, 16'h0002));
        send_beat(tick_beat(32'h0000_0003, 16'h0002));  // 19 ms
        send_beat(tick_beat(32'h0000_0004, 16'h0002));  // 20 ms
        send_beat(tick_beat(32'd5, 16'h0000));           // held to idle
        send_beat(tick_beat(32'd6, 16'h0002));
        send_beat(tick_beat(32'd7, 16'h0000));           // bounce: settling to idle
        // disabled block keeps running but reports nothing, largest limit
        write_cfg(1'b0, 16'hFFFF, 16'h0000, 1'b0);
        send_beat(tick_beat(32'd1000, 16'h0001));
        send_beat(read_beat(CH_W'(1), 1'b1));            // zero, latch kept
        send_beat(tick_beat(32'd1000 + 32'd65534, 16'hFFFD));  // upper pins ignored
        send_beat(tick_beat(32'd1000 + 32'd65535, 16'h0001));
        write_cfg(1'b1, 16'hFFFF, 16'hFFFF, 1'b0);
        send_beat(read_beat(CH_W'(1), 1'b0));
        send_beat(read_beat(CH_W'(0), 1'b1));
        send_beat(read_beat(CH_W'(NUM_CHANNELS), 1'b1)); // first channel past the end
    endtask

    // press/release sequences with jittery time steps, reads and noise
    task automatic test_random_traffic();
        logic                    ens    [6] = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
        logic [LIMIT_W-1:0]      limits [6] = '{16'd50, 16'd0, 16'hFFFF, 16'd20, 16'd0, 16'd10};
        logic [PIN_W-1:0]        masks  [6] = '{16'h0003, 16'h0000, 16'hFFFF,
                                                16'h5A5A, 16'h0000, 16'h0001};
        int                      snd_idle  [6] = '{0, 68, 0, 11, 0, 0};
        int                      rcv_stall [6] = '{0, 0, 68, 11, 0, 68};
        logic [TIME_W-1:0]       clock_ms;
        logic [NUM_CHANNELS-1:0] want_active;
        logic [PIN_W-1:0]        pins;
        logic [CH_W-1:0]         ch;
        t_beat                   beat;
        int                      pick;
        limits[4] = LIMIT_W'($urandom_range(1, 40));
        masks[4]  = PIN_W'($urandom());
        for (int r = 0; r < 6; r++) begin
            write_cfg(ens[r], limits[r], masks[r], r == 3);
            snd_idle_pct  = snd_idle[r];
            rcv_stall_pct = rcv_stall[r];
            // odd rounds start just short of the wrap
            clock_ms    = (r % 2 == 1) ? 32'hFFFF_FFFF - $urandom_range(0, 3000) : $urandom();
            want_active = '0;
            repeat (ROUND_BEATS) begin
                pick = $urandom_range(99);
                if (pick < 10) begin
                    // noise: arbitrary time and levels
                    beat = tick_beat($urandom(), PIN_W'($urandom()));
                end else if (pick < 30) begin
                    ch = ($urandom_range(3) == 0) ? CH_W'($urandom())
                                                  : CH_W'($urandom_range(NUM_CHANNELS - 1));
                    beat = read_beat(ch, 1'($urandom()));
                end else begin
                    // mostly small steps, now and then a long jump
                    clock_ms = clock_ms + (($urandom_range(19) == 0) ? $urandom_range(0, 100000)
                                                                     : $urandom_range(0, 25));
                    for (int c = 0; c < NUM_CHANNELS; c++) begin
                        if ($urandom_range(5) == 0) begin
                            want_active[c] = ~want_active[c];
                        end
                    end
                    pins = PIN_W'($urandom());
                    pins[NUM_CHANNELS-1:0] = want_active ^ cfg_mask[NUM_CHANNELS-1:0];
                    beat = tick_beat(clock_ms, pins);
                end
                send_beat(beat);
            end
        end
    endtask

    // receiver holds off long enough to fill the block, then the sender
    // pauses until everything is back before a final burst
    task automatic test_backpressure();
        logic [TIME_W-1:0] clock_ms;
        write_cfg(1'b1, 16'd30, 16'h0002, 1'b0);
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        clock_ms      = $urandom();
        hold_left     = HOLD_OFF_CYCLES;
        for (int k = 0; k < 20; k++) begin
            clock_ms = clock_ms + 7;
            if (k % 5 == 4) begin
                send_beat(read_beat(CH_W'(k % 2), 1'b1));
            end else begin
                // both channels active with this mask
                send_beat(tick_beat(clock_ms, {14'($urandom()), 2'b01}));
            end
        end
        wait_drained();
        for (int k = 0; k < 10; k++) begin
            clock_ms = clock_ms + 11;
            if (k % 3 == 2) begin
                send_beat(read_beat(CH_W'(k % 2), 1'($urandom())));
            end else begin
                send_beat(tick_beat(clock_ms, PIN_W'($urandom())));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // sequencing
    // ------------------------------------------------------------------------

    initial begin
        i_rst_n            = 1'b0;
        i_cfg_valid        = 1'b0;
        i_cfg_index        = CFG_BLOCK_ENABLE;
        i_cfg_data         = '0;
        i_in_valid         = 1'b0;
        i_op               = OP_TICK;
        i_now_ms           = '0;
        i_pin_levels       = '0;
        i_channel          = '0;
        i_clear_after_read = 1'b0;
        i_out_ready        = 1'b0;
        mismatches         = 0;
        snd_idle_pct       = 0;
        rcv_stall_pct      = 0;
        hold_left          = 0;
        quiet_cycles       = 0;
        cfg_en             = RST_BLOCK_ENABLE;
        cfg_limit          = RST_DEBOUNCE_MS;
        cfg_mask           = RST_ACTIVE_LOW_MASK;
        click_latch        = '0;
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            btn_phase[c]   = BTN_RELEASED;
            press_start[c] = '0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_values();
        test_special_cases();
        test_random_traffic();
        test_backpressure();

        // let the last reports out, then wait for stray beats
        wait_drained();
        repeat (4) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
